### rtl/cksf_pkg.sv
// ----------------------------------------------------------------------------
// cksf_pkg: shared types and constants of the cross kernel sharpen filter
// Pixel and result layouts, line store entry and configuration codes.
// ----------------------------------------------------------------------------
package cksf_pkg;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 16;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  // older: pixel two rows up, newer: pixel one row up
  typedef struct packed {
    rgb_t older;
    rgb_t newer;
  } line_ent_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    rgb_t             rgb;
    logic             is_border;
    logic             last_of_run;
    logic             frame_done;
  } res_t;

endpackage

### rtl/cksf_if.sv
// ----------------------------------------------------------------------------
// cksf_if: channel interfaces of the cross kernel sharpen filter
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface cksf_pix_if;
  import cksf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;
  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                output ready);
endinterface

interface cksf_res_if;
  import cksf_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             is_border;
  logic             last_of_run;
  logic             frame_done;
  modport source (output valid, output out_col, output out_row, output out_red,
                  output out_green, output out_blue, output is_border,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input out_col, input out_row, input out_red,
                input out_green, input out_blue, input is_border,
                input last_of_run, input frame_done, output ready);
endinterface

interface cksf_cfg_if;
  import cksf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/cksf_line_store.sv
// ----------------------------------------------------------------------------
// cksf_line_store: two-row line store memory
// One write and one registered read per cycle, write data forwarded on a
// same-address read.
// ----------------------------------------------------------------------------
module cksf_line_store #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  cksf_pkg::line_ent_t      wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output cksf_pkg::line_ent_t      rdata
);
  import cksf_pkg::*;

  line_ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

### rtl/cksf_out_fifo.sv
// ----------------------------------------------------------------------------
// cksf_out_fifo: two-entry result queue
// Decouples the result channel from the filter stage.
// ----------------------------------------------------------------------------
module cksf_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cksf_pkg::res_t   push_data,
  output logic             can_push,
  cksf_res_if.source       out_res
);
  import cksf_pkg::*;

  localparam logic [1:0] FULL = 2'd2;

  res_t       q_r [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic       pop;
  res_t       head;

  assign pop      = out_res.valid && out_res.ready;
  assign can_push = (cnt_r != FULL);
  assign cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  assign head     = q_r[rd_ptr_r];

  assign out_res.valid       = (cnt_r != 2'd0);
  assign out_res.out_col     = head.col;
  assign out_res.out_row     = head.row;
  assign out_res.out_red     = head.rgb.red;
  assign out_res.out_green   = head.rgb.green;
  assign out_res.out_blue    = head.rgb.blue;
  assign out_res.is_border   = head.is_border;
  assign out_res.last_of_run = head.last_of_run;
  assign out_res.frame_done  = head.frame_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != FULL))
    else $error("push into full result queue");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count did not rise on push");

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("queue count did not fall on pop");

endmodule

### rtl/cross_kernel_sharpen_filter_unit.sv
// ----------------------------------------------------------------------------
// cross_kernel_sharpen_filter_unit: 3x3 cross sharpening of an RGB stream
// Raster-order pixels in, border pass-through and filtered pixels out.
// ----------------------------------------------------------------------------
// throughput: one pixel per clock while the result queue has room, set by one line
// store read and write per pixel; a last-row pixel below an interior pixel causes
// two results and holds the input until the first is pushed into the result queue,
// the result channel moving one result per cycle while out_res.ready is high
// reset: counters, filter stage and result queue cleared, size set to 640 x 480;
// line store contents are not cleared
module cross_kernel_sharpen_filter_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input logic        clk,
  input logic        rst_n,
  cksf_pix_if.sink   in_pix,
  cksf_res_if.source out_res,
  cksf_cfg_if.sink   cfg_wr
);
  import cksf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MAXI = EW'(MAX_WIDTH - 1);

  function automatic logic [PIX_W-1:0] sharpen(input logic [PIX_W-1:0] u,
                                               input logic [PIX_W-1:0] l,
                                               input logic [PIX_W-1:0] c,
                                               input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] d);
    logic [PIX_W+3:0] v;
    v = ({4'b0, c} << 2) + {4'b0, c} - {4'b0, u} - {4'b0, l} - {4'b0, r}
      - {4'b0, d};
    if (v[PIX_W+3]) begin
      sharpen = '0;
    end else if (v[PIX_W+2:PIX_W] != 3'd0) begin
      sharpen = '1;
    end else begin
      sharpen = v[PIX_W-1:0];
    end
  endfunction

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  rgb_t             prev_left_r;

  logic             s1_filt_r;
  logic             s1_bord_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  rgb_t             s1_cur_r;
  rgb_t             s1_up_r;
  rgb_t             s1_ctr_r;
  rgb_t             s1_lft_r;
  logic             s1_done_r;

  logic [EW-1:0]    w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [EW-1:0]    col_ext;
  logic [EW-1:0]    col_inc;
  logic [ROW_W:0]   row_inc;
  logic [EW-1:0]    rd_col;
  logic [EW-1:0]    wr_clamp;
  logic [EW-1:0]    rd_clamp;
  logic             last_col;
  logic             last_row;
  logic             border;
  logic             filt_hit;
  logic             in_acc;
  logic             pending;
  logic             can_push;
  logic             push;
  rgb_t             cur;
  line_ent_t        rd_data;
  line_ent_t        wr_data;
  rgb_t             right;
  rgb_t             filt_rgb;
  res_t             push_data;

  // configuration
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.index)
        REG_FRAME_WIDTH:  fw_r <= cfg_wr.wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_wr.wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // position decode
  always_comb begin
    if (fw_r == '0) begin
      w_eff = EW'(1);
    end else if (EW'(fw_r) > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = EW'(fw_r);
    end
    h_eff    = (fh_r == '0) ? FH_W'(1) : fh_r;
    col_ext  = EW'(col_r);
    col_inc  = col_ext + EW'(1);
    row_inc  = {1'b0, row_r} + (ROW_W + 1)'(1);
    last_col = (col_inc >= w_eff);
    last_row = (row_inc >= {1'b0, h_eff});
    border   = (col_r == '0) || last_col || (row_r == '0) || last_row;
    filt_hit = (row_r >= ROW_W'(2)) && (row_r < h_eff) && (col_r != '0)
            && (col_inc < w_eff);
    rd_col   = last_col ? '0 : EW'(col_inc[COL_W-1:0]);
    wr_clamp = (col_ext < MAXW) ? col_ext : MAXI;
    rd_clamp = (rd_col < MAXW) ? rd_col : MAXI;
    col_nxt  = rd_col[COL_W-1:0];
    if (last_col) begin
      row_nxt = last_row ? '0 : row_inc[ROW_W-1:0];
    end else begin
      row_nxt = row_r;
    end
  end

  assign cur     = '{red: in_pix.in_red, green: in_pix.in_green, blue: in_pix.in_blue};
  assign wr_data = '{older: rd_data.newer, newer: cur};

  // input handshake
  assign pending      = s1_filt_r || s1_bord_r;
  assign push         = pending && can_push;
  assign in_pix.ready = !pending || (can_push && !(s1_filt_r && s1_bord_r));
  assign in_acc       = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_filt_r <= 1'b0;
      s1_bord_r <= 1'b0;
    end else if (in_acc) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      s1_filt_r <= filt_hit;
      s1_bord_r <= border;
    end else if (push) begin
      if (s1_filt_r) begin
        s1_filt_r <= 1'b0;
      end else begin
        s1_bord_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      s1_cur_r    <= cur;
      s1_up_r     <= rd_data.older;
      s1_ctr_r    <= rd_data.newer;
      s1_lft_r    <= prev_left_r;
      s1_done_r   <= last_col && last_row;
      prev_left_r <= rd_data.newer;
    end
  end

  cksf_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wr_clamp[AW-1:0]),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (rd_clamp[AW-1:0]),
    .rdata (rd_data)
  );

  // filter stage, right neighbour arrives from the line store read
  assign right = rd_data.newer;

  always_comb begin
    filt_rgb.red   = sharpen(s1_up_r.red, s1_lft_r.red, s1_ctr_r.red, right.red,
                             s1_cur_r.red);
    filt_rgb.green = sharpen(s1_up_r.green, s1_lft_r.green, s1_ctr_r.green,
                             right.green, s1_cur_r.green);
    filt_rgb.blue  = sharpen(s1_up_r.blue, s1_lft_r.blue, s1_ctr_r.blue, right.blue,
                             s1_cur_r.blue);
    if (s1_filt_r) begin
      push_data.col         = s1_col_r;
      push_data.row         = s1_row_r - ROW_W'(1);
      push_data.rgb         = filt_rgb;
      push_data.is_border   = 1'b0;
      push_data.last_of_run = !s1_bord_r;
      push_data.frame_done  = 1'b0;
    end else begin
      push_data.col         = s1_col_r;
      push_data.row         = s1_row_r;
      push_data.rgb         = s1_cur_r;
      push_data.is_border   = 1'b1;
      push_data.last_of_run = 1'b1;
      push_data.frame_done  = s1_done_r;
    end
  end

  cksf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .out_res   (out_res)
  );

  a_two_pending_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_filt_r && s1_bord_r) |-> !in_pix.ready)
    else $error("input taken while two results pending");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last_col) |=> (col_r == '0))
    else $error("column counter did not wrap");

  a_right_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_filt_r && !in_acc) |=> $stable(rd_data))
    else $error("line store data moved under a pending filtered result");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the cross kernel sharpen filter unit
// Streams raster-order RGB frames of many sizes through the filter with random
// gaps on the pixel and result channels. A scoreboard models the line stores
// and counters, predicts border pass-through and sharpened pixels with their
// coordinates and flags, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cksf_pkg::*;

  localparam int LINE_DEPTH    = 2048;
  localparam int DRAIN_CYCLES  = 8;
  localparam int END_CYCLES    = 10;
  localparam int RANDOM_PIXELS = 1100;

  typedef enum int {PAT_RANDOM, PAT_SMOOTH, PAT_EXTREME, PAT_CHECKER} pix_pattern_t;

  class sharpen_scoreboard;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    rgb_t            line_up1 [LINE_DEPTH];
    rgb_t            line_up2 [LINE_DEPTH];
    int unsigned     col_at;
    int unsigned     row_at;
    res_t            due_results [$];
    int              errors;
    int              filtered_seen;
    int              border_seen;

    function new();
      width_reg     = FW_RESET;
      height_reg    = FH_RESET;
      col_at        = 0;
      row_at        = 0;
      errors        = 0;
      filtered_seen = 0;
      border_seen   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH: width_reg = data[FW_W-1:0];
        REG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : 32'(height_reg);
    endfunction

    function int unsigned frame_pixels();
      return eff_width() * eff_height();
    endfunction

    function logic [PIX_W-1:0] sharpen_chan(logic [PIX_W-1:0] up, logic [PIX_W-1:0] lf,
                                            logic [PIX_W-1:0] ce, logic [PIX_W-1:0] rt,
                                            logic [PIX_W-1:0] dn);
      int v;
      v = 5 * int'(ce) - int'(up) - int'(lf) - int'(rt) - int'(dn);
      if (v > 255) v = 255;
      if (v < 0) v = 0;
      return PIX_W'(v);
    endfunction

    function void note_pixel(rgb_t px);
      int unsigned      w;
      int unsigned      h;
      logic             last_col;
      logic             last_row;
      logic             on_border;
      logic [COL_W-1:0] ci;
      logic [COL_W-1:0] cl;
      logic [COL_W-1:0] cr;
      res_t             r;
      w         = eff_width();
      h         = eff_height();
      ci        = COL_W'(col_at);
      cl        = ci - COL_W'(1);
      cr        = ci + COL_W'(1);
      last_col  = (col_at + 1 >= w);
      last_row  = (row_at + 1 >= h);
      on_border = (col_at == 0) || last_col || (row_at == 0) || last_row;
      // pixel above is complete once its lower neighbour arrives
      if (row_at >= 2 && row_at < h && col_at >= 1 && col_at + 1 < w) begin
        r.col           = COL_W'(col_at);
        r.row           = ROW_W'(row_at - 1);
        r.rgb.red       = sharpen_chan(line_up2[ci].red, line_up2[cl].red,
                                       line_up1[ci].red, line_up1[cr].red, px.red);
        r.rgb.green     = sharpen_chan(line_up2[ci].green, line_up2[cl].green,
                                       line_up1[ci].green, line_up1[cr].green,
                                       px.green);
        r.rgb.blue      = sharpen_chan(line_up2[ci].blue, line_up2[cl].blue,
                                       line_up1[ci].blue, line_up1[cr].blue,
                                       px.blue);
        r.is_border     = 1'b0;
        r.last_of_run   = !on_border;
        r.frame_done    = 1'b0;
        due_results.push_back(r);
      end
      if (on_border) begin
        r.col         = COL_W'(col_at);
        r.row         = ROW_W'(row_at);
        r.rgb         = px;
        r.is_border   = 1'b1;
        r.last_of_run = 1'b1;
        r.frame_done  = last_col && last_row;
        due_results.push_back(r);
      end
      line_up2[ci] = line_up1[ci];
      line_up1[ci] = px;
      if (last_col) begin
        col_at = 0;
        row_at = last_row ? 0 : ((row_at + 1) & 32'hFFFF);
      end else begin
        col_at = (col_at + 1) & 32'h7FF;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none actual col %0d row %0d",
                 $time, got.col, got.row);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("out_col", 32'(want.col), 32'(got.col));
      compare_field("out_row", 32'(want.row), 32'(got.row));
      compare_field("out_red", 32'(want.rgb.red), 32'(got.rgb.red));
      compare_field("out_green", 32'(want.rgb.green), 32'(got.rgb.green));
      compare_field("out_blue", 32'(want.rgb.blue), 32'(got.rgb.blue));
      compare_field("is_border", 32'(want.is_border), 32'(got.is_border));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
      if (want.is_border) border_seen++;
      else filtered_seen++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   frames_sent;
  int   pixels_sent;

  sharpen_scoreboard sb = new();

  cksf_pix_if pix_if ();
  cksf_res_if res_if ();
  cksf_cfg_if cfg_if ();

  cross_kernel_sharpen_filter_unit #(
    .MAX_WIDTH(LINE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_if),
    .out_res(res_if),
    .cfg_wr (cfg_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic rgb_t make_pixel(pix_pattern_t pat, int base);
    rgb_t px;
    case (pat)
      PAT_SMOOTH: begin
        px.red   = PIX_W'(base + $urandom_range(0, 40));
        px.green = PIX_W'(base + $urandom_range(0, 40));
        px.blue  = PIX_W'(base + $urandom_range(0, 40));
      end
      PAT_EXTREME: begin
        px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      PAT_CHECKER: begin
        // clamps red and green both high and low, blue stays in range
        if (((sb.col_at + sb.row_at) & 1) == 0) px = '{8'hFF, 8'h00, 8'h64};
        else px = '{8'h00, 8'hFF, 8'h64};
      end
      default: begin
        px.red   = PIX_W'($urandom);
        px.green = PIX_W'($urandom);
        px.blue  = PIX_W'($urandom);
      end
    endcase
    return px;
  endfunction

  // entered and left at a falling edge
  task automatic push_pixel(rgb_t px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.in_red   <= px.red;
    pix_if.in_green <= px.green;
    pix_if.in_blue  <= px.blue;
    do @(posedge clk); while (pix_if.ready !== 1'b1);
    sb.note_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  // block drained before every register write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    pix_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_frame(int w, int h, pix_pattern_t pat);
    int base;
    int total;
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    base  = $urandom_range(0, 215);
    total = sb.frame_pixels();
    for (int i = 0; i < total; i++) push_pixel(make_pixel(pat, base));
    frames_sent++;
  endtask

  // result side backpressure
  initial begin
    int n;
    res_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got.col         = res_if.out_col;
      got.row         = res_if.out_row;
      got.rgb.red     = res_if.out_red;
      got.rgb.green   = res_if.out_green;
      got.rgb.blue    = res_if.out_blue;
      got.is_border   = res_if.is_border;
      got.last_of_run = res_if.last_of_run;
      got.frame_done  = res_if.frame_done;
      sb.check_result(got);
    end
  end

  initial begin
    int start;
    int w;
    int h;
    int roll;
    rst_n           = 1'b0;
    calm            = 1'b0;
    frames_sent     = 0;
    pixels_sent     = 0;
    pix_if.valid    = 1'b0;
    pix_if.in_red   = '0;
    pix_if.in_green = '0;
    pix_if.in_blue  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_FRAME_WIDTH;
    cfg_if.wdata    = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // start at the reset size, then shrink width and height mid-frame
    push_pixel('{8'h00, 8'h00, 8'h00});
    push_pixel('{8'hFF, 8'hFF, 8'hFF});
    push_pixel('{8'hAA, 8'h55, 8'h80});
    write_reg(REG_FRAME_WIDTH, 16'd2);
    push_pixel('{8'h55, 8'hAA, 8'h7F});
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    push_pixel(make_pixel(PAT_RANDOM, 0));
    push_pixel(make_pixel(PAT_RANDOM, 0));
    frames_sent++;

    // smallest frame with an interior pixel, clamping both ways
    send_frame(3, 3, PAT_CHECKER);
    // zero sizes act as one pixel
    send_frame(0, 0, PAT_EXTREME);
    send_frame(0, 0, PAT_EXTREME);
    // too short for any interior pixel
    send_frame(2, 2, PAT_RANDOM);

    // full height, cut short mid-frame
    write_reg(REG_FRAME_WIDTH, 16'd3);
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    repeat (6) push_pixel(make_pixel(PAT_RANDOM, 0));
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    repeat (3) push_pixel(make_pixel(PAT_RANDOM, 0));
    frames_sent++;

    // oversize width, cut short mid-row
    write_reg(REG_FRAME_WIDTH, 16'd4095);
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    repeat (5) push_pixel(make_pixel(PAT_RANDOM, 0));
    write_reg(REG_FRAME_WIDTH, 16'd5);
    repeat (6) push_pixel(make_pixel(PAT_RANDOM, 0));
    frames_sent++;

    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) w = $urandom_range(1, 2);
      else if (roll < 8) w = $urandom_range(3, 10);
      else w = $urandom_range(11, 40);
      h    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      calm = ($urandom_range(0, 4) == 0);
      send_frame(w, h, pix_pattern_t'($urandom_range(0, 3)));
    end
    calm = 1'b0;

    pix_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);
    $display("run covered %0d frames and %0d pixels, widths from zero to oversize,",
             frames_sent, pixels_sent);
    $display("heights up to full range, %0d filtered and %0d border results checked",
             sb.filtered_seen, sb.border_seen);
    if (sb.errors == 0) begin
      $display("cross_kernel_sharpen_filter_unit test passed");
    end else begin
      $display("cross_kernel_sharpen_filter_unit test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d results still pending", sb.due_results.size());
    $display("cross_kernel_sharpen_filter_unit test failed");
    $finish;
  end

endmodule
